@@ design/lkt_pkg.sv @@
// ---------------------------------------------------------------------------
// lkt_pkg
// Shared types and constants for the last pressed key tracker.
// ---------------------------------------------------------------------------
package lkt_pkg;

    localparam int NUM_KEYS = 4;
    localparam int LEVEL_W  = 4;
    localparam int STAMP_W  = 32;
    localparam int KEY_W    = $clog2(NUM_KEYS + 1);
    localparam int EVENT_W  = 2;

    typedef logic [KEY_W-1:0]   key_idx_t;
    typedef logic [STAMP_W-1:0] stamp_t;
    typedef stamp_t [NUM_KEYS-1:0] stamp_arr_t;
    typedef key_idx_t [NUM_KEYS-1:0] key_idx_arr_t;

    typedef enum logic [EVENT_W-1:0] {
        EV_NONE     = 2'd0,
        EV_PRESSED  = 2'd1,
        EV_RELEASED = 2'd2
    } event_t;

    typedef event_t [NUM_KEYS-1:0] event_arr_t;

    localparam key_idx_t NO_KEY = key_idx_t'(NUM_KEYS);

    typedef struct packed {
        key_idx_t active;
        event_t   overall;
    } merge_t;

endpackage

@@ design/lkt_in_if.sv @@
// ---------------------------------------------------------------------------
// lkt_in_if
// Sample channel: button levels, timestamp and consumed flag.
// ---------------------------------------------------------------------------
interface lkt_in_if;

    logic                        valid;
    logic                        ready;
    logic [lkt_pkg::LEVEL_W-1:0] key_levels;
    lkt_pkg::stamp_t             sample_time;
    logic                        consumed;

    modport source (
        output valid,
        output key_levels,
        output sample_time,
        output consumed,
        input  ready
    );

    modport sink (
        input  valid,
        input  key_levels,
        input  sample_time,
        input  consumed,
        output ready
    );

endinterface

@@ design/lkt_out_if.sv @@
// ---------------------------------------------------------------------------
// lkt_out_if
// Result channel: held mask, per-key events, active key, overall event.
// ---------------------------------------------------------------------------
interface lkt_out_if;

    logic                                               valid;
    logic                                               ready;
    logic [lkt_pkg::NUM_KEYS-1:0]                       held_mask;
    logic [lkt_pkg::EVENT_W*lkt_pkg::NUM_KEYS-1:0]      key_events;
    lkt_pkg::key_idx_t                                  active_key;
    logic [lkt_pkg::EVENT_W-1:0]                        active_event;

    modport source (
        output valid,
        output held_mask,
        output key_events,
        output active_key,
        output active_event,
        input  ready
    );

    modport sink (
        input  valid,
        input  held_mask,
        input  key_events,
        input  active_key,
        input  active_event,
        output ready
    );

endinterface

@@ design/lkt_lane.sv @@
// ---------------------------------------------------------------------------
// lkt_lane
// Per-key lane: newest held key with a nonzero stamp, lowest index on ties.
// ---------------------------------------------------------------------------
module lkt_lane (
    input  logic [lkt_pkg::NUM_KEYS-1:0] held,
    input  lkt_pkg::stamp_arr_t          stamps,
    output lkt_pkg::key_idx_t            best
);

    always_comb
    begin
        lkt_pkg::stamp_t best_stamp;
        best_stamp = '0;
        best       = lkt_pkg::NO_KEY;
        for (int j = 0; j < lkt_pkg::NUM_KEYS; j++)
        begin
            if (held[j] && (stamps[j] > best_stamp))
            begin
                best       = lkt_pkg::key_idx_t'(j);
                best_stamp = stamps[j];
            end
        end
    end

endmodule

@@ design/lkt_merge.sv @@
// ---------------------------------------------------------------------------
// lkt_merge
// Walks the keys in index order and combines the lane picks into the
// new active key and the overall event.
// ---------------------------------------------------------------------------
module lkt_merge (
    input  logic [lkt_pkg::NUM_KEYS-1:0] level,
    input  logic [lkt_pkg::NUM_KEYS-1:0] held,
    input  lkt_pkg::key_idx_t            active,
    input  lkt_pkg::key_idx_arr_t        cand,
    output lkt_pkg::merge_t              res
);

    always_comb
    begin
        lkt_pkg::key_idx_t act;
        lkt_pkg::event_t   ov;
        act = active;
        ov  = lkt_pkg::EV_NONE;
        for (int k = 0; k < lkt_pkg::NUM_KEYS; k++)
        begin
            if (level[k])
            begin
                if (act == lkt_pkg::NO_KEY)
                begin
                    ov = lkt_pkg::EV_PRESSED;
                end
                if (!held[k])
                begin
                    act = lkt_pkg::key_idx_t'(k);
                end
            end
            else if (act == lkt_pkg::key_idx_t'(k))
            begin
                act = cand[k];
                if (cand[k] == lkt_pkg::NO_KEY)
                begin
                    ov = lkt_pkg::EV_RELEASED;
                end
            end
        end
        res.active  = act;
        res.overall = ov;
    end

endmodule

@@ design/last_pressed_key_tracker.sv @@
// ---------------------------------------------------------------------------
// last_pressed_key_tracker
// Tracks held keys, per-key press/release events and the most recently
// pressed held key.
// ---------------------------------------------------------------------------
// Usage:
//   samples : sink channel, one item per button sample (levels, timestamp,
//             consumed flag). Items with consumed low leave all state as is.
//   results : source channel, one item per accepted sample, showing the
//             state after that sample.
//   Result valid follows in the cycle after sample acceptance; one item per
//   cycle is sustained unless results stall. The result register doubles as
//   the tracker state, so a new sample is taken in the same cycle the previous
//   result drains. Timing is set by the per-key lanes (a chain of stamp
//   compares) feeding the in-order merge of the active key.
//   When the receiver stalls, the result holds and samples.ready stays low
//   until the result is taken.
//   Reset clears all keys, events and stamps, sets the active key to none
//   and empties the result channel.
// ---------------------------------------------------------------------------
module last_pressed_key_tracker (
    input  logic      clk,
    input  logic      rst_n,
    lkt_in_if.sink    samples,
    lkt_out_if.source results
);

    logic [lkt_pkg::NUM_KEYS-1:0] held_reg;
    lkt_pkg::event_arr_t          event_reg;
    lkt_pkg::stamp_arr_t          stamp_reg;
    lkt_pkg::key_idx_t            active_reg;
    lkt_pkg::event_t              overall_reg;
    logic                         valid_reg;

    logic [lkt_pkg::NUM_KEYS-1:0] level;
    lkt_pkg::stamp_arr_t          stamp_next;
    lkt_pkg::event_arr_t          event_next;
    lkt_pkg::key_idx_arr_t        cand;
    lkt_pkg::merge_t              merge_res;
    logic                         accept;
    logic                         update;

    assign samples.ready = !valid_reg || results.ready;
    assign accept        = samples.valid && samples.ready;
    assign update        = accept && samples.consumed;

    genvar k;
    generate
        for (k = 0; k < lkt_pkg::NUM_KEYS; k++)
        begin : g_key
            logic [lkt_pkg::NUM_KEYS-1:0] lane_held;
            lkt_pkg::stamp_arr_t          lane_stamp;

            if (k < lkt_pkg::LEVEL_W)
            begin : g_lvl
                assign level[k] = samples.key_levels[k];
            end
            else
            begin : g_nolvl
                assign level[k] = 1'b0;
            end

            assign stamp_next[k] = (level[k] && !held_reg[k]) ? samples.sample_time
                                                              : stamp_reg[k];

            always_comb
            begin
                if (level[k] && !held_reg[k])
                begin
                    event_next[k] = lkt_pkg::EV_PRESSED;
                end
                else if (!level[k] && held_reg[k])
                begin
                    event_next[k] = lkt_pkg::EV_RELEASED;
                end
                else
                begin
                    event_next[k] = lkt_pkg::EV_NONE;
                end
            end

            // held/stamp view seen by key k during the in-order walk
            always_comb
            begin
                for (int j = 0; j < lkt_pkg::NUM_KEYS; j++)
                begin
                    if (j < k)
                    begin
                        lane_held[j]  = level[j];
                        lane_stamp[j] = stamp_next[j];
                    end
                    else if (j == k)
                    begin
                        lane_held[j]  = 1'b0;
                        lane_stamp[j] = stamp_reg[j];
                    end
                    else
                    begin
                        lane_held[j]  = held_reg[j];
                        lane_stamp[j] = stamp_reg[j];
                    end
                end
            end

            lkt_lane u_lane (
                .held   (lane_held),
                .stamps (lane_stamp),
                .best   (cand[k])
            );
        end
    endgenerate

    lkt_merge u_merge (
        .level  (level),
        .held   (held_reg),
        .active (active_reg),
        .cand   (cand),
        .res    (merge_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg    <= '0;
            event_reg   <= '{default: lkt_pkg::EV_NONE};
            stamp_reg   <= '0;
            active_reg  <= lkt_pkg::NO_KEY;
            overall_reg <= lkt_pkg::EV_NONE;
            valid_reg   <= 1'b0;
        end
        else
        begin
            if (update)
            begin
                held_reg    <= level;
                event_reg   <= event_next;
                stamp_reg   <= stamp_next;
                active_reg  <= merge_res.active;
                overall_reg <= merge_res.overall;
            end
            if (accept)
            begin
                valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    assign results.valid        = valid_reg;
    assign results.held_mask    = held_reg;
    assign results.key_events   = event_reg;
    assign results.active_key   = active_reg;
    assign results.active_event = overall_reg;

endmodule

@@ tb/sv/tb_last_pressed_key_tracker.sv @@
// ---------------------------------------------------------------------------
// tb_last_pressed_key_tracker
// Self-checking regression for the last pressed key tracker. Button samples
// go in through the sample channel with bursty timing. Results are drained
// with a changing stall pattern and one long hold-off. Every result is
// compared field by field against a behavioral tracker kept in this bench.
// ---------------------------------------------------------------------------
module tb_last_pressed_key_tracker;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 160;
    localparam int RANDOM_ITEMS   = 900;
    localparam int DRAIN_CYCLES   = 4;

    typedef struct packed {
        logic [lkt_pkg::NUM_KEYS-1:0]                  held_mask;
        logic [lkt_pkg::EVENT_W*lkt_pkg::NUM_KEYS-1:0] key_events;
        lkt_pkg::key_idx_t                             active_key;
        logic [lkt_pkg::EVENT_W-1:0]                   active_event;
    } key_state_t;

    typedef enum int {
        RX_ALWAYS,
        RX_COIN,
        RX_PERIODIC,
        RX_MOSTLY
    } rx_mode_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    lkt_in_if  samples_if();
    lkt_out_if results_if();

    last_pressed_key_tracker DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples_if),
        .results (results_if)
    );

    always #5 clk = ~clk;

    // behavioral tracker state
    logic [lkt_pkg::NUM_KEYS-1:0] trk_held;
    lkt_pkg::event_arr_t          trk_events;
    lkt_pkg::stamp_arr_t          trk_stamps;
    lkt_pkg::key_idx_t            trk_active;
    lkt_pkg::event_t              trk_overall;

    key_state_t pending_key_states[$];

    int  mismatches       = 0;
    int  samples_sent     = 0;
    int  frozen_sent      = 0;
    int  results_checked  = 0;
    int  first_press_seen = 0;
    int  all_release_seen = 0;
    int  input_stalls     = 0;
    int  idle_cycles      = 0;
    bit  hold_results_req = 1'b0;

    function automatic key_state_t advance_key_tracker(
        logic [lkt_pkg::LEVEL_W-1:0] levels, lkt_pkg::stamp_t now, logic consumed);
        key_state_t        r;
        lkt_pkg::key_idx_t best;
        lkt_pkg::stamp_t   best_stamp;
        if (consumed)
        begin
            trk_overall = lkt_pkg::EV_NONE;
            for (int k = 0; k < lkt_pkg::NUM_KEYS; k++)
            begin
                trk_events[k] = lkt_pkg::EV_NONE;
                if (levels[k])
                begin
                    if (trk_active == lkt_pkg::NO_KEY)
                        trk_overall = lkt_pkg::EV_PRESSED;
                    if (!trk_held[k])
                    begin
                        trk_held[k]   = 1'b1;
                        trk_events[k] = lkt_pkg::EV_PRESSED;
                        trk_stamps[k] = now;
                        trk_active    = lkt_pkg::key_idx_t'(k);
                    end
                end
                else
                begin
                    if (trk_held[k])
                    begin
                        trk_events[k] = lkt_pkg::EV_RELEASED;
                        trk_held[k]   = 1'b0;
                    end
                    if (trk_active == lkt_pkg::key_idx_t'(k))
                    begin
                        // newest held key, zero stamps never qualify
                        best       = lkt_pkg::NO_KEY;
                        best_stamp = '0;
                        for (int j = 0; j < lkt_pkg::NUM_KEYS; j++)
                        begin
                            if (trk_held[j] && trk_stamps[j] > best_stamp)
                            begin
                                best       = lkt_pkg::key_idx_t'(j);
                                best_stamp = trk_stamps[j];
                            end
                        end
                        trk_active = best;
                        if (trk_active == lkt_pkg::NO_KEY)
                            trk_overall = lkt_pkg::EV_RELEASED;
                    end
                end
            end
        end
        r.held_mask = trk_held;
        for (int k = 0; k < lkt_pkg::NUM_KEYS; k++)
            r.key_events[lkt_pkg::EVENT_W*k +: lkt_pkg::EVENT_W] = trk_events[k];
        r.active_key   = trk_active;
        r.active_event = trk_overall;
        return r;
    endfunction

    task automatic report_mismatch(string what, int unsigned want, int unsigned got);
        $display("[%0t] mismatch on %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
        mismatches++;
    endtask

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_sample(logic [lkt_pkg::LEVEL_W-1:0] levels, lkt_pkg::stamp_t now,
                               logic consumed);
        samples_if.valid       <= 1'b1;
        samples_if.key_levels  <= levels;
        samples_if.sample_time <= now;
        samples_if.consumed    <= consumed;
        @(posedge clk);
        while (!samples_if.ready)
            @(posedge clk);
        pending_key_states.push_back(advance_key_tracker(levels, now, consumed));
        samples_sent++;
        if (!consumed)
            frozen_sent++;
        @(negedge clk);
    endtask

    task automatic idle_sender(int cycles);
        samples_if.valid <= 1'b0;
        repeat (cycles) @(negedge clk);
    endtask

    task automatic test_press_release();
        send_sample(4'b0000, 32'd0,          1'b1);
        send_sample(4'b0001, 32'd100,        1'b1);
        send_sample(4'b0011, 32'd200,        1'b1);
        send_sample(4'b0001, 32'd300,        1'b1);
        send_sample(4'b1111, 32'hFFFF_FFFF,  1'b1);
        send_sample(4'b0111, 32'd400,        1'b1);
        send_sample(4'b0000, 32'd500,        1'b1);
        send_sample(4'b1010, 32'h5555_5555,  1'b1);
        send_sample(4'b0101, 32'hAAAA_AAAA,  1'b1);
        send_sample(4'b0000, 32'd0,          1'b1);
        idle_sender(3);
    endtask

    task automatic test_frozen_update();
        send_sample(4'b0010, 32'd10,         1'b1);
        send_sample(4'b1101, 32'hFFFF_FFFF,  1'b0);
        send_sample(4'b0000, 32'd0,          1'b0);
        send_sample(4'b1101, 32'd20,         1'b1);
        idle_sender(2);
    endtask

    task automatic test_zero_stamp();
        send_sample(4'b0000, 32'd0, 1'b1);
        send_sample(4'b0001, 32'd0, 1'b1);
        send_sample(4'b0011, 32'd7, 1'b1);
        // key 1 goes up, key 0 has a zero stamp so nothing is active
        send_sample(4'b0001, 32'd8, 1'b1);
        // key 0 still held while nothing active: first press again
        send_sample(4'b0001, 32'd9, 1'b1);
        send_sample(4'b0000, 32'd9, 1'b1);
        idle_sender(4);
    endtask

    task automatic test_stamp_ties();
        send_sample(4'b0110, 32'd50, 1'b1);
        send_sample(4'b1110, 32'd50, 1'b1);
        send_sample(4'b0110, 32'd60, 1'b1);
        send_sample(4'b0100, 32'd70, 1'b1);
        send_sample(4'b0000, 32'd80, 1'b1);
        idle_sender(2);
    endtask

    task automatic test_result_backpressure();
        lkt_pkg::stamp_t tick;
        tick = 32'h0001_0000;
        hold_results_req = 1'b1;
        for (int n = 0; n < 40; n++)
        begin
            tick += lkt_pkg::stamp_t'($urandom_range(0, 2));
            send_sample(lkt_pkg::LEVEL_W'($urandom), tick, ($urandom_range(0, 9) != 0));
        end
        idle_sender(3);
    endtask

    task automatic test_random_traffic();
        logic [lkt_pkg::LEVEL_W-1:0] levels;
        lkt_pkg::stamp_t             tick;
        lkt_pkg::stamp_t             now;
        int                          burst;
        int                          pick;
        int                          bit_idx;
        int                          n;
        levels = '0;
        tick   = lkt_pkg::stamp_t'($urandom_range(1, 5000));
        n      = 0;
        while (n < RANDOM_ITEMS)
        begin
            burst = $urandom_range(1, 24);
            for (int b = 0; b < burst && n < RANDOM_ITEMS; b++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 70)
                begin
                    bit_idx = $urandom_range(0, lkt_pkg::LEVEL_W - 1);
                    levels[bit_idx] = ~levels[bit_idx];
                end
                else if (pick < 90)
                    levels = lkt_pkg::LEVEL_W'($urandom);
                tick += lkt_pkg::stamp_t'($urandom_range(0, 3));
                pick = $urandom_range(0, 99);
                if (pick < 5)
                    now = lkt_pkg::stamp_t'($urandom);
                else if (pick < 8)
                    now = '0;
                else if (pick < 10)
                    now = '1;
                else
                    now = tick;
                send_sample(levels, now, ($urandom_range(0, 99) < 85));
                n++;
            end
            if ($urandom_range(0, 2) != 0)
                idle_sender($urandom_range(1, 6));
        end
        idle_sender(1);
    endtask

    // receiver: stall pattern steps through the four rx modes in turn, plus one long hold-off
    initial
    begin
        rx_mode_t mode;
        int       rx_cycle;
        results_if.ready = 1'b0;
        rx_cycle = 0;
        forever
        begin
            @(negedge clk);
            if (hold_results_req)
            begin
                hold_results_req = 1'b0;
                results_if.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end
            else
            begin
                mode = rx_mode_t'((rx_cycle / 50) % 4);
                case (mode)
                    RX_ALWAYS:   results_if.ready <= 1'b1;
                    RX_COIN:     results_if.ready <= 1'($urandom_range(0, 1));
                    RX_PERIODIC: results_if.ready <= (rx_cycle % 4 != 3);
                    default:     results_if.ready <= ($urandom_range(0, 99) < 85);
                endcase
            end
            rx_cycle++;
        end
    end

    always @(posedge clk)
    begin
        key_state_t want;
        if (rst_n && results_if.valid && results_if.ready)
        begin
            if (pending_key_states.size() == 0)
                report_mismatch("result with nothing pending", 0, 0);
            else
            begin
                want = pending_key_states.pop_front();
                if (results_if.held_mask !== want.held_mask)
                    report_mismatch("held_mask", 32'(want.held_mask),
                                    32'(results_if.held_mask));
                if (results_if.key_events !== want.key_events)
                    report_mismatch("key_events", 32'(want.key_events),
                                    32'(results_if.key_events));
                if (results_if.active_key !== want.active_key)
                    report_mismatch("active_key", 32'(want.active_key),
                                    32'(results_if.active_key));
                if (results_if.active_event !== want.active_event)
                    report_mismatch("active_event", 32'(want.active_event),
                                    32'(results_if.active_event));
                if (want.active_event == lkt_pkg::EV_PRESSED)
                    first_press_seen++;
                if (want.active_event == lkt_pkg::EV_RELEASED)
                    all_release_seen++;
                results_checked++;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (samples_if.valid && !samples_if.ready)
                input_stalls++;
            if ((samples_if.valid && samples_if.ready) ||
                (results_if.valid && results_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("[%0t] watchdog: no progress for %0d cycles", $time, idle_cycles);
                $display("last_pressed_key_tracker regression: fail");
                $finish;
            end
        end
    end

    initial
    begin
        samples_if.valid       = 1'b0;
        samples_if.key_levels  = '0;
        samples_if.sample_time = '0;
        samples_if.consumed    = 1'b0;
        trk_held    = '0;
        trk_stamps  = '0;
        trk_active  = lkt_pkg::NO_KEY;
        trk_overall = lkt_pkg::EV_NONE;
        for (int k = 0; k < lkt_pkg::NUM_KEYS; k++)
            trk_events[k] = lkt_pkg::EV_NONE;

        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_press_release();
        test_frozen_update();
        test_zero_stamp();
        test_stamp_ties();
        test_result_backpressure();
        test_random_traffic();

        while (pending_key_states.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d samples (%0d frozen), %0d results checked, %0d input stall cycles",
                 samples_sent, frozen_sent, results_checked, input_stalls);
        $display("saw %0d first-press and %0d all-released events, %0d mismatches",
                 first_press_seen, all_release_seen, mismatches);
        if (mismatches == 0)
            $display("last_pressed_key_tracker regression: pass");
        else
            $display("last_pressed_key_tracker regression: fail");
        $finish;
    end

endmodule

@@ filelist.f @@
design/lkt_pkg.sv
design/lkt_in_if.sv
design/lkt_out_if.sv
design/lkt_lane.sv
design/lkt_merge.sv
design/last_pressed_key_tracker.sv
tb/sv/tb_last_pressed_key_tracker.sv
